// ===== rtl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, types and helper functions of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int MAX_ORDER = 10;
    localparam int PAGES     = 1 << MAX_ORDER;

    // Fixed port field widths
    localparam int SIZE_W  = 11;
    localparam int PAGE_W  = 10;
    localparam int ORDER_W = 4;
    localparam int STAT_W  = 2;

    // Free map layout: low orders live in a word memory, high orders in flops
    localparam int LOG_W   = 5;
    localparam int WORD_W  = 1 << LOG_W;
    localparam int LOWN    = MAX_ORDER - LOG_W;
    localparam int NROWS   = (2 << LOWN) - 2;
    localparam int ROW_W   = $clog2(NROWS);
    localparam int NORD    = MAX_ORDER + 1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
    localparam logic [STAT_W-1:0] ST_OOM = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNK = 2'd3;

    // Command kinds after classification
    localparam logic [1:0] K_ALLOC = 2'd0;
    localparam logic [1:0] K_FREE  = 2'd1;
    localparam logic [1:0] K_BAD   = 2'd2;

    localparam logic OP_ALLOC = 1'b0;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ORDER_W-1:0] order;
        logic [PAGE_W-1:0]  page;
    } t_cmd;

    // First memory row of a low order
    function automatic logic [ROW_W-1:0] row_base(input logic [ORDER_W-1:0] o);
        logic [ROW_W:0] span;
        span = (ROW_W+1)'(2 << LOWN);
        return ROW_W'(span - (span >> o));
    endfunction

    // Row summary bits belonging to one low order
    function automatic t_word rows_of(input logic [NROWS-1:0] nz,
                                      input logic [ORDER_W-1:0] o);
        logic [NROWS-1:0] s;
        logic [WORD_W:0]  m;
        s = nz >> row_base(o);
        m = ((WORD_W+1)'(1) << ((WORD_W+1)'(1) << (LOWN[ORDER_W-1:0] - o))) - 1'b1;
        return WORD_W'(s) & m[WORD_W-1:0];
    endfunction

    function automatic logic [LOG_W-1:0] pe_word(input t_word v);
        logic [LOG_W-1:0] r;
        r = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (v[k]) begin
                r = LOG_W'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [ORDER_W-1:0] pe_ord(input logic [NORD-1:0] v);
        logic [ORDER_W-1:0] r;
        r = '0;
        for (int k = NORD - 1; k >= 0; k--) begin
            if (v[k]) begin
                r = ORDER_W'(k);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/bpa_front.sv =====
// ----------------------------------------------------------------------------
// bpa_front
// Takes requests, checks size and rounds it to an order, queues commands.
// ----------------------------------------------------------------------------
module bpa_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic                        i_opcode,
    input  logic [bpa_pkg::SIZE_W-1:0]  i_size_pages,
    input  logic [bpa_pkg::PAGE_W-1:0]  i_start_page,
    output logic                        o_cmd_valid,
    output bpa_pkg::t_cmd               o_cmd,
    input  logic                        i_cmd_pop
);

    bpa_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    bpa_pkg::t_cmd cls;
    logic          push_ok;
    logic          pop_ok;

    always_comb begin
        cls.page  = i_start_page;
        cls.order = '0;
        for (int t = bpa_pkg::MAX_ORDER; t >= 0; t--) begin
            if ((32'(1) << t) >= 32'(i_size_pages)) begin
                cls.order = bpa_pkg::ORDER_W'(t);
            end
        end
        if (i_opcode != bpa_pkg::OP_ALLOC) begin
            cls.kind = bpa_pkg::K_FREE;
        end else if (i_size_pages == '0 || 32'(i_size_pages) > 32'(bpa_pkg::PAGES)) begin
            cls.kind = bpa_pkg::K_BAD;
        end else begin
            cls.kind = bpa_pkg::K_ALLOC;
        end
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= !r_wp;
            end
            if (pop_ok) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push_ok) - 2'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

// ===== rtl/bpa_back.sv =====
// ----------------------------------------------------------------------------
// bpa_back
// Executes allocate and free commands on the free map and page records.
// ----------------------------------------------------------------------------
module bpa_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  bpa_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_clearing,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [bpa_pkg::PAGE_W-1:0]    o_page_index,
    output logic [bpa_pkg::ORDER_W-1:0]   o_block_order,
    output logic [bpa_pkg::STAT_W-1:0]    o_status
);

    localparam logic [2:0] S_CLR    = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_AFIND  = 3'd2;
    localparam logic [2:0] S_ARD    = 3'd3;
    localparam logic [2:0] S_ASPLIT = 3'd4;
    localparam logic [2:0] S_FREC   = 3'd5;
    localparam logic [2:0] S_FMRG   = 3'd6;
    localparam logic [2:0] S_FRD    = 3'd7;

    localparam int ORD_W = bpa_pkg::ORDER_W;
    localparam int PW    = bpa_pkg::PAGE_W;
    localparam int LW    = bpa_pkg::LOG_W;
    localparam int RW    = bpa_pkg::ROW_W;
    localparam logic [ORD_W-1:0] O_MAX  = ORD_W'(bpa_pkg::MAX_ORDER);
    localparam logic [ORD_W-1:0] O_LOWN = ORD_W'(bpa_pkg::LOWN);

    logic [2:0]                  r_state, n_state;
    logic [PW-1:0]               r_clr, n_clr;
    logic [ORD_W-1:0]            r_o, n_o, r_tgt, n_tgt, r_ford, n_ford;
    logic [PW-1:0]               r_idx, n_idx, r_page, n_page;
    logic [bpa_pkg::NROWS-1:0]   r_nz, n_nz;
    bpa_pkg::t_word              r_hi [bpa_pkg::NORD];
    bpa_pkg::t_word              n_hi [bpa_pkg::NORD];
    logic                        r_res_valid, n_res_valid;
    logic [PW-1:0]               r_res_page, n_res_page;
    logic [ORD_W-1:0]            r_res_ord, n_res_ord;
    logic [bpa_pkg::STAT_W-1:0]  r_res_st, n_res_st;

    // Word memory for the low orders
    bpa_pkg::t_word              r_fmem [bpa_pkg::NROWS];
    bpa_pkg::t_word              r_fq;
    logic                        fm_rd, fm_we;
    logic [RW-1:0]               fm_raddr, fm_waddr;
    bpa_pkg::t_word              fm_wdata;

    // Page records: valid bit and order
    logic [ORD_W:0]              r_rec [bpa_pkg::PAGES];
    logic [ORD_W:0]              r_recq;
    logic                        rc_rd, rc_we;
    logic [PW-1:0]               rc_raddr, rc_waddr;
    logic [ORD_W:0]              rc_wdata;

    logic [bpa_pkg::NORD-1:0]    any_free, cand;
    logic [ORD_W-1:0]            osel, o_dn;
    logic [LW-1:0]               bsel, bb;
    logic [RW-1:0]               row;
    logic [PW-1:0]               i_dn;
    bpa_pkg::t_word              q, nq;

    always_comb begin
        for (int o = 0; o < bpa_pkg::NORD; o++) begin
            if (o < bpa_pkg::LOWN) begin
                any_free[o] = |bpa_pkg::rows_of(r_nz, ORD_W'(o));
            end else begin
                any_free[o] = |r_hi[o];
            end
            cand[o] = any_free[o] && (ORD_W'(o) >= r_tgt);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_o         = r_o;
        n_tgt       = r_tgt;
        n_ford      = r_ford;
        n_idx       = r_idx;
        n_page      = r_page;
        n_nz        = r_nz;
        n_hi        = r_hi;
        n_res_valid = r_res_valid;
        n_res_page  = r_res_page;
        n_res_ord   = r_res_ord;
        n_res_st    = r_res_st;
        o_cmd_pop   = 1'b0;
        fm_rd       = 1'b0;
        fm_raddr    = '0;
        fm_we       = 1'b0;
        fm_waddr    = '0;
        fm_wdata    = '0;
        rc_rd       = 1'b0;
        rc_raddr    = i_cmd.page;
        rc_we       = 1'b0;
        rc_waddr    = '0;
        rc_wdata    = '0;
        osel        = bpa_pkg::pe_ord(cand);
        o_dn        = r_o - 1'b1;
        i_dn        = r_idx << 1;
        bsel        = '0;
        bb          = r_idx[LW-1:0] ^ LW'(1);
        row         = bpa_pkg::row_base(r_o) + RW'(r_idx >> LW);
        q           = r_nz[row] ? r_fq : '0;
        nq          = '0;

        if (i_pop && r_res_valid) begin
            n_res_valid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                rc_we    = 1'b1;
                rc_waddr = r_clr;
                n_clr    = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && !r_res_valid) begin
                    o_cmd_pop = 1'b1;
                    n_tgt     = i_cmd.order;
                    n_page    = i_cmd.page;
                    case (i_cmd.kind)
                        bpa_pkg::K_ALLOC: n_state = S_AFIND;
                        bpa_pkg::K_FREE: begin
                            rc_rd   = 1'b1;
                            n_state = S_FREC;
                        end
                        default: begin
                            n_res_valid = 1'b1;
                            n_res_page  = '0;
                            n_res_ord   = '0;
                            n_res_st    = bpa_pkg::ST_BAD;
                        end
                    endcase
                end
            end
            S_AFIND: begin
                n_o = osel;
                if (!(|cand)) begin
                    n_res_valid = 1'b1;
                    n_res_page  = '0;
                    n_res_ord   = '0;
                    n_res_st    = bpa_pkg::ST_OOM;
                    n_state     = S_IDLE;
                end else if (osel >= O_LOWN) begin
                    bsel             = bpa_pkg::pe_word(r_hi[osel]);
                    n_hi[osel][bsel] = 1'b0;
                    n_idx            = PW'(bsel);
                    n_state          = S_ASPLIT;
                end else begin
                    bsel     = bpa_pkg::pe_word(bpa_pkg::rows_of(r_nz, osel));
                    fm_rd    = 1'b1;
                    fm_raddr = bpa_pkg::row_base(osel) + RW'(bsel);
                    n_idx    = PW'(bsel);
                    n_state  = S_ARD;
                end
            end
            S_ARD: begin
                // r_idx holds the word index here
                row       = bpa_pkg::row_base(r_o) + RW'(r_idx);
                bsel      = bpa_pkg::pe_word(r_fq);
                nq        = r_fq & ~(bpa_pkg::t_word'(1) << bsel);
                fm_we     = 1'b1;
                fm_waddr  = row;
                fm_wdata  = nq;
                n_nz[row] = |nq;
                n_idx     = (r_idx << LW) | PW'(bsel);
                n_state   = S_ASPLIT;
            end
            S_ASPLIT: begin
                if (r_o == r_tgt) begin
                    rc_we       = 1'b1;
                    rc_waddr    = r_idx << r_tgt;
                    rc_wdata    = {1'b1, r_tgt};
                    n_res_valid = 1'b1;
                    n_res_page  = r_idx << r_tgt;
                    n_res_ord   = r_tgt;
                    n_res_st    = bpa_pkg::ST_OK;
                    n_state     = S_IDLE;
                end else begin
                    // Orders below the one taken hold no free block: write the buddy alone
                    if (o_dn >= O_LOWN) begin
                        n_hi[o_dn][i_dn[LW-1:0] | LW'(1)] = 1'b1;
                    end else begin
                        row       = bpa_pkg::row_base(o_dn) + RW'(i_dn >> LW);
                        fm_we     = 1'b1;
                        fm_waddr  = row;
                        fm_wdata  = bpa_pkg::t_word'(1) << (i_dn[LW-1:0] | LW'(1));
                        n_nz[row] = 1'b1;
                    end
                    n_o   = o_dn;
                    n_idx = i_dn;
                end
            end
            S_FREC: begin
                if (!r_recq[ORD_W]) begin
                    n_res_valid = 1'b1;
                    n_res_page  = '0;
                    n_res_ord   = '0;
                    n_res_st    = bpa_pkg::ST_UNK;
                    n_state     = S_IDLE;
                end else begin
                    rc_we    = 1'b1;
                    rc_waddr = r_page;
                    rc_wdata = '0;
                    n_o      = r_recq[ORD_W-1:0];
                    n_ford   = r_recq[ORD_W-1:0];
                    n_idx    = r_page >> r_recq[ORD_W-1:0];
                    n_state  = S_FMRG;
                end
            end
            S_FMRG: begin
                if (r_o >= O_MAX) begin
                    n_hi[O_MAX][0] = 1'b1;
                    n_res_valid    = 1'b1;
                    n_res_page     = r_page;
                    n_res_ord      = r_ford;
                    n_res_st       = bpa_pkg::ST_OK;
                    n_state        = S_IDLE;
                end else if (r_o >= O_LOWN) begin
                    if (r_hi[r_o][bb]) begin
                        n_hi[r_o][bb] = 1'b0;
                        n_idx         = r_idx >> 1;
                        n_o           = r_o + 1'b1;
                    end else begin
                        n_hi[r_o][r_idx[LW-1:0]] = 1'b1;
                        n_res_valid = 1'b1;
                        n_res_page  = r_page;
                        n_res_ord   = r_ford;
                        n_res_st    = bpa_pkg::ST_OK;
                        n_state     = S_IDLE;
                    end
                end else begin
                    fm_rd    = 1'b1;
                    fm_raddr = row;
                    n_state  = S_FRD;
                end
            end
            S_FRD: begin
                fm_we    = 1'b1;
                fm_waddr = row;
                if (q[bb]) begin
                    // Buddy free: take it out and climb one order
                    nq        = q & ~(bpa_pkg::t_word'(1) << bb);
                    n_nz[row] = |nq;
                    n_idx     = r_idx >> 1;
                    n_o       = r_o + 1'b1;
                    n_state   = S_FMRG;
                end else begin
                    nq          = q | (bpa_pkg::t_word'(1) << r_idx[LW-1:0]);
                    n_nz[row]   = 1'b1;
                    n_res_valid = 1'b1;
                    n_res_page  = r_page;
                    n_res_ord   = r_ford;
                    n_res_st    = bpa_pkg::ST_OK;
                    n_state     = S_IDLE;
                end
                fm_wdata = nq;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_nz        <= '0;
            r_res_valid <= 1'b0;
            // Only the whole-region block starts free
            for (int o = 0; o < bpa_pkg::NORD; o++) begin
                r_hi[o] <= (o == bpa_pkg::MAX_ORDER) ? bpa_pkg::t_word'(1) : '0;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_nz        <= n_nz;
            r_res_valid <= n_res_valid;
            r_hi        <= n_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o        <= n_o;
        r_tgt      <= n_tgt;
        r_ford     <= n_ford;
        r_idx      <= n_idx;
        r_page     <= n_page;
        r_res_page <= n_res_page;
        r_res_ord  <= n_res_ord;
        r_res_st   <= n_res_st;
    end

    always_ff @(posedge i_clk) begin
        if (fm_we) begin
            r_fmem[fm_waddr] <= fm_wdata;
        end
        if (fm_rd) begin
            r_fq <= r_fmem[fm_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rc_we) begin
            r_rec[rc_waddr] <= rc_wdata;
        end
        if (rc_rd) begin
            r_recq <= r_rec[rc_raddr];
        end
    end

    assign o_clearing    = (r_state == S_CLR);
    assign o_empty       = !r_res_valid;
    assign o_page_index  = r_res_page;
    assign o_block_order = r_res_ord;
    assign o_status      = r_res_st;

endmodule

// ===== rtl/buddy_page_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Binary buddy allocator over 1024 pages with a queue interface.
// ----------------------------------------------------------------------------
// After reset the block sweeps its page record memory and holds o_full
// high meanwhile. An allocate finds the lowest free order at or above the
// request, reads the word memory when the block comes from there (orders
// below 5), then takes one split step per order split. A free reads the
// page record, then merges with one read and one write of the free map word
// memory per level at orders below 5 and one step per level from order 5 up. Requests are queued
// two deep in front of the executing engine, so pushes continue while a result
// waits.
module buddy_page_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_opcode,
    input  logic [bpa_pkg::SIZE_W-1:0]    i_size_pages,
    input  logic [bpa_pkg::PAGE_W-1:0]    i_start_page,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [bpa_pkg::PAGE_W-1:0]    o_page_index,
    output logic [bpa_pkg::ORDER_W-1:0]   o_block_order,
    output logic [bpa_pkg::STAT_W-1:0]    o_status
);

    logic          front_full;
    logic          clearing;
    logic          cmd_valid;
    logic          cmd_pop;
    bpa_pkg::t_cmd cmd;

    assign o_full = front_full || clearing;

    bpa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push && !clearing),
        .o_full       (front_full),
        .i_opcode     (i_opcode),
        .i_size_pages (i_size_pages),
        .i_start_page (i_start_page),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    bpa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .o_clearing    (clearing),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_page_index  (o_page_index),
        .o_block_order (o_block_order),
        .o_status      (o_status)
    );

`ifndef NO_ASSERTIONS
    a_full_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_full)
        else $error("queue open during record sweep");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_status != bpa_pkg::ST_OK) |->
            (o_page_index == '0 && o_block_order == '0))
        else $error("error result carries nonzero fields");

    a_order_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_block_order <= bpa_pkg::ORDER_W'(bpa_pkg::MAX_ORDER)))
        else $error("result order out of range");
`endif

endmodule
